>>> hdl/bitmap_row_run_encoder_top_defines.svh
// Assertion macros for the bitmap row run encoder.
// Used by bitmap_row_run_encoder_top.sv; no other dependencies.
`ifndef BITMAP_ROW_RUN_ENCODER_TOP_DEFINES_SVH
`define BITMAP_ROW_RUN_ENCODER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// The consequent holds in the same cycle as the antecedent.
`define BRRE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");
// The consequent holds in the cycle after the antecedent.
`define BRRE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");
`else
`define BRRE_ASSERT_SAME(label, clk, rst, ante, cons)
`define BRRE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hdl/brre_pkg.sv
// Package for the bitmap row run encoder: constants, codes and the result type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package brre_pkg;

   // Image bounds.
   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;

   // State widths, large enough to hold the bound itself.
   localparam int COL_W = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W = $clog2(MAX_HEIGHT + 1);

   // Result field widths.
   localparam int DX_W  = 7;
   localparam int DY_W  = 6;
   localparam int LEN_W = 7;
   localparam int CNT_W = 13;
   localparam int CMD_W = 2;

   // Arithmetic width for the masked differences.
   localparam int CALC_W = (COL_W > DX_W) ? ((COL_W > LEN_W) ? COL_W : LEN_W)
                                          : ((DX_W > LEN_W) ? DX_W : LEN_W);
   localparam int RCALC_W = (ROW_W > DY_W) ? ROW_W : DY_W;

   // Stream payload widths.
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;

   // Configuration reset value.
   localparam logic [CNT_W-1:0] CAPACITY_RESET = CNT_W'(64);

   // Request commands.
   typedef enum logic [CMD_W-1:0] {
      CMD_PIXEL      = 2'd0,
      CMD_END_ROW    = 2'd1,
      CMD_END_IMAGE  = 2'd2
   } brre_cmd_type;

   // Result kinds.
   localparam logic KIND_RUN     = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // One result.
   typedef struct packed {
      logic             kind;
      logic [DX_W-1:0]  move_dx;
      logic [DY_W-1:0]  move_dy;
      logic [LEN_W-1:0] run_length;
      logic             stored;
      logic [CNT_W-1:0] delta_count;
      logic             last;
   } brre_result_type;

endpackage
`default_nettype wire

>>> hdl/bitmap_row_run_encoder_top.sv
// Top level of the bitmap row run encoder: run detection, pen tracking and
// an output queue. Depends on brre_pkg and bitmap_row_run_encoder_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_row_run_encoder_top_defines.svh"

// The encoder takes one request per clock cycle while req_tready is high and
// updates its column, row, run and pen state in that same cycle. A pixel or
// end-of-row request gives at most one result; an end-of-image request gives a
// run record if a run is open and then the summary, so it may give two. Results
// enter a four-entry output queue; req_tready is high while at least two entries
// are free, so a consumer that takes one result per cycle sees one request per
// cycle sustained, with a first result in the cycle after its request. Capacity
// is written via csr_we/csr_wdata only while idle; the user must ensure this.
module bitmap_row_run_encoder_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request channel. tdata: pixel_set [0], zero [7:1]. tuser: command [1:0].
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [brre_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic [brre_pkg::CMD_W-1:0]        req_tuser,
   // Result channel. tdata: move_dx [6:0], move_dy [12:7], run_length [19:13],
   // stored [20], delta_count [33:21], zero [39:34]. tuser: kind.
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [brre_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                   rsp_tuser,
   output logic                                   rsp_tlast,
   // Configuration: capacity register.
   input  wire logic                              csr_we,
   input  wire logic [brre_pkg::CNT_W-1:0]        csr_wdata
);
   import brre_pkg::*;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // State registers.
   logic [CNT_W-1:0] capacity_ff;
   logic [COL_W-1:0] column_ff, column_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             run_open_ff, run_open_in;
   logic [COL_W-1:0] run_start_ff, run_start_in;
   logic [COL_W-1:0] pen_col_ff, pen_col_in;
   logic [ROW_W-1:0] pen_row_ff, pen_row_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Output queue.
   brre_result_type  queue_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] qcnt_ff;

   // Request decode.
   logic [CMD_W-1:0] cmd;
   logic             px;
   logic             accept;
   logic             pop;
   logic             row_live;
   logic             col_live;
   logic             close_run;
   logic             emit_sum;
   logic             cap_ok;
   logic [CNT_W-1:0] count_close;
   logic [CALC_W-1:0] dx_full, len_full;
   logic [RCALC_W-1:0] dy_full;
   brre_result_type  run_res, sum_res;
   logic [1:0]       push_n;

   assign cmd      = req_tuser;
   assign px       = req_tdata[0];
   assign req_tready = (qcnt_ff <= QCNT_W'(QDEPTH - 2));
   assign accept   = req_tvalid && req_tready;
   assign pop      = rsp_tvalid && rsp_tready;
   assign row_live = (row_ff < ROW_W'(MAX_HEIGHT));
   assign col_live = (column_ff < COL_W'(MAX_WIDTH));

   // Decide which results this request causes.
   always_comb begin
      close_run = 1'b0;
      emit_sum  = 1'b0;
      case (cmd)
         CMD_PIXEL: begin
            close_run = row_live && col_live && !px && run_open_ff;
         end
         CMD_END_ROW: begin
            close_run = row_live && run_open_ff;
         end
         CMD_END_IMAGE: begin
            close_run = run_open_ff;
            emit_sum  = 1'b1;
         end
         default: begin
            close_run = 1'b0;
            emit_sum  = 1'b0;
         end
      endcase
   end

   // Run record fields and the capacity check.
   assign cap_ok      = ({1'b0, count_ff} + (CNT_W + 1)'(1)) < {1'b0, capacity_ff};
   assign count_close = (close_run && cap_ok) ? count_ff + CNT_W'(2) : count_ff;
   assign dx_full     = CALC_W'(run_start_ff) - CALC_W'(pen_col_ff);
   assign len_full    = CALC_W'(column_ff) - CALC_W'(run_start_ff);
   assign dy_full     = RCALC_W'(row_ff) - RCALC_W'(pen_row_ff);

   always_comb begin
      run_res.kind        = KIND_RUN;
      run_res.move_dx     = dx_full[DX_W-1:0];
      run_res.move_dy     = dy_full[DY_W-1:0];
      run_res.run_length  = len_full[LEN_W-1:0];
      run_res.stored      = cap_ok;
      run_res.delta_count = count_close;
      run_res.last        = !emit_sum;
      sum_res.kind        = KIND_SUMMARY;
      sum_res.move_dx     = '0;
      sum_res.move_dy     = '0;
      sum_res.run_length  = '0;
      sum_res.stored      = 1'b0;
      sum_res.delta_count = count_close;
      sum_res.last        = 1'b1;
      push_n = accept ? (2'(close_run) + 2'(emit_sum)) : 2'd0;
   end

   // Next image state.
   always_comb begin
      column_in    = column_ff;
      row_in       = row_ff;
      run_open_in  = run_open_ff;
      run_start_in = run_start_ff;
      pen_col_in   = pen_col_ff;
      pen_row_in   = pen_row_ff;
      count_in     = count_close;
      if (close_run) begin
         pen_col_in  = column_ff;
         pen_row_in  = row_ff;
         run_open_in = 1'b0;
      end
      case (cmd)
         CMD_PIXEL: begin
            if (row_live && col_live) begin
               if (px && !run_open_ff) begin
                  run_open_in  = 1'b1;
                  run_start_in = column_ff;
               end
               column_in = column_ff + COL_W'(1);
            end
         end
         CMD_END_ROW: begin
            if (row_live) begin
               column_in = '0;
               row_in    = row_ff + ROW_W'(1);
            end
         end
         CMD_END_IMAGE: begin
            column_in    = '0;
            row_in       = '0;
            run_open_in  = 1'b0;
            run_start_in = '0;
            pen_col_in   = '0;
            pen_row_in   = '0;
            count_in     = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // State, configuration and queue control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         column_ff    <= '0;
         row_ff       <= '0;
         run_open_ff  <= 1'b0;
         run_start_ff <= '0;
         pen_col_ff   <= '0;
         pen_row_ff   <= '0;
         count_ff     <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         qcnt_ff      <= '0;
      end else begin
         if (csr_we) begin
            capacity_ff <= csr_wdata;
         end
         if (accept) begin
            column_ff    <= column_in;
            row_ff       <= row_in;
            run_open_ff  <= run_open_in;
            run_start_ff <= run_start_in;
            pen_col_ff   <= pen_col_in;
            pen_row_ff   <= pen_row_in;
            count_ff     <= count_in;
         end
         wr_ptr_ff <= wr_ptr_ff + QPTR_W'(push_n);
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         qcnt_ff <= qcnt_ff + QCNT_W'(push_n) - QCNT_W'(pop);
      end
   end

   // Queue payload writes: the run record first, then the summary.
   always_ff @(posedge clock) begin
      if (accept) begin
         if (close_run) begin
            queue_ff[wr_ptr_ff] <= run_res;
            if (emit_sum) begin
               queue_ff[wr_ptr_ff + QPTR_W'(1)] <= sum_res;
            end
         end else if (emit_sum) begin
            queue_ff[wr_ptr_ff] <= sum_res;
         end
      end
   end

   // Result channel from the queue head.
   brre_result_type head;
   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tvalid = (qcnt_ff != '0);
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;
   assign rsp_tdata  = {6'd0, head.delta_count, head.stored, head.run_length,
                        head.move_dy, head.move_dx};

   // Checks.
   `BRRE_ASSERT_SAME(a_queue_bound, clock, reset, 1'b1, qcnt_ff <= QCNT_W'(QDEPTH))
   `BRRE_ASSERT_SAME(a_summary_last, clock, reset, rsp_tvalid && head.kind == KIND_SUMMARY,
      head.last && head.run_length == '0)
   `BRRE_ASSERT_SAME(a_run_nonempty, clock, reset, rsp_tvalid && head.kind == KIND_RUN,
      head.run_length != '0)
   `BRRE_ASSERT_NEXT(a_eoi_clears, clock, reset, accept && cmd == CMD_END_IMAGE,
      count_ff == '0 && !run_open_ff && column_ff == '0 && row_ff == '0)

endmodule
`default_nettype wire

>>> tb/sv/tb_bitmap_row_run_encoder_top.sv
// Self-checking testbench for bitmap_row_run_encoder_top: streams pixel requests,
// predicts run records and summaries, and checks them. Depends on brre_pkg and the RTL.
`timescale 1ns / 1ps

module tb_bitmap_row_run_encoder_top;
   import brre_pkg::*;

   // Field offsets inside rsp_tdata, lowest field first.
   localparam int DY_LSB     = DX_W;
   localparam int LEN_LSB    = DY_LSB + DY_W;
   localparam int STORED_BIT = LEN_LSB + LEN_W;
   localparam int CNT_LSB    = STORED_BIT + 1;

   // Command code that the block ignores.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 80;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0]      req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CNT_W-1:0]      csr_wdata = '0;

   // Requests waiting to be sent as {pixel_set, command}, and records the
   // encoder should produce.
   logic [CMD_W:0]        pixel_stream [$];
   brre_result_type       predicted_records [$];

   // Encoder state as the predictor sees it.
   int unsigned capacity_reg;
   int          image_col;
   int          image_row;
   bit          run_active;
   int          run_first_col;
   int          pen_col;
   int          pen_row;
   int unsigned delta_total;

   bit req_hs = 1'b0;
   bit calm = 1'b0;
   int gap_left = 0;
   int stall_left = 0;
   int queued = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   bitmap_row_run_encoder_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Return the predictor to the start of an image.
   function automatic void clear_image();
      image_col     = 0;
      image_row     = 0;
      run_active    = 1'b0;
      run_first_col = 0;
      pen_col       = 0;
      pen_row       = 0;
      delta_total   = 0;
   endfunction

   // Close the open run, which ends just before the current column.
   task automatic close_run(output brre_result_type rec);
      rec            = '0;
      rec.kind       = KIND_RUN;
      rec.move_dx    = DX_W'(run_first_col - pen_col);
      rec.move_dy    = DY_W'(image_row - pen_row);
      rec.run_length = LEN_W'(image_col - run_first_col);
      if (delta_total + 1 < capacity_reg) begin
         delta_total = delta_total + 2;
         rec.stored  = 1'b1;
      end
      rec.delta_count = CNT_W'(delta_total);
      pen_col    = image_col;
      pen_row    = image_row;
      run_active = 1'b0;
   endtask

   // Work out the records that one accepted request causes.
   task automatic encode_request(input logic [CMD_W-1:0] cmd, input logic px);
      brre_result_type recs [2];
      int n;
      n = 0;
      case (cmd)
         CMD_PIXEL: begin
            if (image_row < MAX_HEIGHT && image_col < MAX_WIDTH) begin
               if (px) begin
                  if (!run_active) begin
                     run_active    = 1'b1;
                     run_first_col = image_col;
                  end
               end else if (run_active) begin
                  close_run(recs[n]);
                  n++;
               end
               image_col++;
            end
         end
         CMD_END_ROW: begin
            if (image_row < MAX_HEIGHT) begin
               if (run_active) begin
                  close_run(recs[n]);
                  n++;
               end
               image_col = 0;
               image_row++;
            end
         end
         CMD_END_IMAGE: begin
            if (run_active) begin
               close_run(recs[n]);
               n++;
            end
            recs[n]             = '0;
            recs[n].kind        = KIND_SUMMARY;
            recs[n].delta_count = CNT_W'(delta_total);
            n++;
            clear_image();
         end
         default: ;
      endcase
      if (n > 0) recs[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) predicted_records.push_back(recs[i]);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] seen);
      if (want !== seen) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
         mismatch_count++;
      end
   endtask

   // Predictor and result checker, both sampled at the rising edge.
   always @(posedge clock) begin : monitor
      brre_result_type want;
      if (reset) begin
         clear_image();
         capacity_reg = CAPACITY_RESET;
         req_hs <= 1'b0;
      end else begin
         req_hs <= req_tvalid && req_tready;
         if (csr_we) capacity_reg = csr_wdata;
         if (req_tvalid && req_tready) encode_request(req_tuser, req_tdata[0]);
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_records.size() == 0) begin
               $display("%0t: unexpected record, expected none, actual tdata %h tuser %b",
                        $time, rsp_tdata, rsp_tuser);
               mismatch_count++;
            end else begin
               want = predicted_records.pop_front();
               check_field("kind", want.kind, rsp_tuser);
               check_field("move_dx", want.move_dx, rsp_tdata[DX_W-1:0]);
               check_field("move_dy", want.move_dy, rsp_tdata[DY_LSB +: DY_W]);
               check_field("run_length", want.run_length, rsp_tdata[LEN_LSB +: LEN_W]);
               check_field("stored", want.stored, rsp_tdata[STORED_BIT]);
               check_field("delta_count", want.delta_count, rsp_tdata[CNT_LSB +: CNT_W]);
               check_field("last", want.last, rsp_tlast);
            end
         end
      end
   end

   // Request driver: presents queued requests, with random gaps between them.
   always @(negedge clock) begin : driver
      logic [CMD_W:0] next_req;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_hs) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(0, 13);
            req_tvalid <= 1'b0;
         end else if (pixel_stream.size() > 0) begin
            next_req = pixel_stream.pop_front();
            req_tuser  <= next_req[CMD_W-1:0];
            req_tdata  <= REQ_DATA_W'(next_req[CMD_W]);
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result sink: stalls in random bursts.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 13);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Run guard.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic add_request(input logic [CMD_W-1:0] cmd, input logic px);
      pixel_stream.push_back({px, cmd});
      queued++;
   endtask

   // An ignored request now and then; it does not count as an item.
   task automatic add_noise();
      if ($urandom_range(0, 15) == 0)
         pixel_stream.push_back({1'($urandom_range(0, 1)), CMD_UNUSED});
   endtask

   // One random image: mostly well formed, sometimes ragged rows or a missing end.
   task automatic add_image();
      int   width;
      int   height;
      int   w;
      logic px;
      width  = ($urandom_range(0, 14) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 12);
      height = (width > 40) ? $urandom_range(1, 2) : $urandom_range(1, 5);
      px     = 1'b0;
      for (int r = 0; r < height; r++) begin
         w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, width) : width;
         for (int c = 0; c < w; c++) begin
            if ($urandom_range(0, 2) == 0) px = $urandom_range(0, 1);
            add_noise();
            add_request(CMD_PIXEL, px);
         end
         if (r < height - 1 || $urandom_range(0, 2) != 0)
            add_request(CMD_END_ROW, $urandom_range(0, 1));
      end
      add_noise();
      if ($urandom_range(0, 11) != 0) add_request(CMD_END_IMAGE, $urandom_range(0, 1));
   endtask

   // Wait until every request is in and every record is out, then let the block settle.
   task automatic wait_idle();
      do begin
         @(posedge clock);
         #1;
      end while (pixel_stream.size() != 0 || req_tvalid || predicted_records.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      #1;
   endtask

   task automatic write_capacity(input int unsigned value);
      @(negedge clock);
      csr_wdata <= CNT_W'(value);
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      #1;
   endtask

   initial begin : stimulus
      int unsigned cap;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      #1;

      // Directed part at the reset capacity: short runs, empty row, run closed by
      // end of image, lone end of image, ignored command, pixel_set on other commands.
      add_request(CMD_PIXEL, 1'b1);
      add_request(CMD_PIXEL, 1'b0);
      add_request(CMD_UNUSED, 1'b1);
      add_request(CMD_PIXEL, 1'b1);
      add_request(CMD_PIXEL, 1'b1);
      add_request(CMD_END_ROW, 1'b1);
      add_request(CMD_END_ROW, 1'b0);
      add_request(CMD_PIXEL, 1'b0);
      add_request(CMD_PIXEL, 1'b1);
      add_request(CMD_END_IMAGE, 1'b1);
      add_request(CMD_END_IMAGE, 1'b0);
      add_request(CMD_UNUSED, 1'b0);
      wait_idle();

      // Capacity two holds exactly one record; the second is dropped.
      write_capacity(2);
      add_request(CMD_PIXEL, 1'b1);
      add_request(CMD_END_ROW, 1'b0);
      add_request(CMD_PIXEL, 1'b1);
      add_request(CMD_PIXEL, 1'b0);
      add_request(CMD_END_IMAGE, 1'b0);
      wait_idle();

      // Capacity zero stores nothing.
      write_capacity(0);
      add_request(CMD_PIXEL, 1'b1);
      add_request(CMD_END_IMAGE, 1'b1);
      wait_idle();

      // Random phases, each at its own capacity; the last one runs without random gaps or stalls.
      for (int p = 0; p < 7; p++) begin
         case (p)
            0: cap = 1;
            1: cap = 4096;
            2: cap = 3;
            3: cap = 4095;
            4: cap = $urandom_range(4, 40);
            5: cap = 0;
            default: cap = 64;
         endcase
         write_capacity(cap);
         calm   = (p == 6);
         queued = 0;
         if (p == 1) begin
            // Full-width row with pixels past the width, then a run at column zero.
            for (int c = 0; c < MAX_WIDTH + 2; c++) add_request(CMD_PIXEL, 1'b1);
            add_request(CMD_END_ROW, 1'b0);
            add_request(CMD_PIXEL, 1'b1);
            add_request(CMD_PIXEL, 1'b0);
            add_request(CMD_END_IMAGE, 1'b0);
            // Tall image: run at the far column, a run on the last row, then
            // requests past the height that must be ignored.
            for (int c = 0; c < MAX_WIDTH; c++) add_request(CMD_PIXEL, c == MAX_WIDTH - 1);
            for (int r = 0; r < MAX_HEIGHT - 1; r++) add_request(CMD_END_ROW, 1'b0);
            add_request(CMD_PIXEL, 1'b1);
            add_request(CMD_END_ROW, 1'b0);
            add_request(CMD_PIXEL, 1'b1);
            add_request(CMD_END_ROW, 1'b1);
            add_request(CMD_PIXEL, 1'b0);
            add_request(CMD_END_IMAGE, 1'b0);
         end
         while (queued < PHASE_ITEMS) add_image();
         add_request(CMD_END_IMAGE, 1'b0);
         wait_idle();
      end

      repeat (20) @(posedge clock);
      #1;
      if (mismatch_count == 0 && predicted_records.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+hdl
hdl/brre_pkg.sv
hdl/bitmap_row_run_encoder_top.sv
tb/sv/tb_bitmap_row_run_encoder_top.sv
